// ===== src/assert_macros.svh =====
// Assertion macros shared by the lexer modules (clock clk, reset rst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define JTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jtl_pkg.sv =====
// Types, codes and character helpers for the JSON token lexer.
package jtl_pkg;

    localparam logic [3:0] KIND_END     = 4'd0;
    localparam logic [3:0] KIND_LBRACK  = 4'd1;
    localparam logic [3:0] KIND_RBRACK  = 4'd2;
    localparam logic [3:0] KIND_LBRACE  = 4'd3;
    localparam logic [3:0] KIND_RBRACE  = 4'd4;
    localparam logic [3:0] KIND_COLON   = 4'd5;
    localparam logic [3:0] KIND_COMMA   = 4'd6;
    localparam logic [3:0] KIND_STRING  = 4'd7;
    localparam logic [3:0] KIND_NUMBER  = 4'd8;
    localparam logic [3:0] KIND_TRUE    = 4'd9;
    localparam logic [3:0] KIND_FALSE   = 4'd10;
    localparam logic [3:0] KIND_NULL    = 4'd11;
    localparam logic [3:0] KIND_ERROR   = 4'd12;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_STRAY    = 3'd1;
    localparam logic [2:0] ERR_UNTERM   = 3'd2;
    localparam logic [2:0] ERR_MINUS    = 3'd3;
    localparam logic [2:0] ERR_FRACTION = 3'd4;
    localparam logic [2:0] ERR_EXPONENT = 3'd5;
    localparam logic [2:0] ERR_LITERAL  = 3'd6;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK    = 8'h5B;
    localparam logic [7:0] CH_RBRACK    = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NUL       = 8'h00;

    localparam int TOK_W       = 24;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    typedef struct packed {
        logic [3:0]       kind;
        logic [2:0]       err;
        logic [TOK_W-1:0] start;
        logic [TOK_W-1:0] len;
        logic             last;
    } tok_t;

    // Up to two tokens handed from the lexer to the output queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok0;
        tok_t       tok1;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // space, tab, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_exp_mark(input logic [7:0] c);
        return (c == 8'h65) || (c == 8'h45);
    endfunction

    // Literal spelling: 0 true, 1 false, 2 null.
    function automatic logic [2:0] lit_len(input logic [1:0] k);
        logic [2:0] r;
        unique case (k)
            2'd1:    r = 3'd5;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] r;
        r = CH_NUL;
        unique case (k)
            2'd0: begin
                unique case (idx)
                    3'd0:    r = 8'h74;
                    3'd1:    r = 8'h72;
                    3'd2:    r = 8'h75;
                    3'd3:    r = 8'h65;
                    default: r = CH_NUL;
                endcase
            end
            2'd1: begin
                unique case (idx)
                    3'd0:    r = 8'h66;
                    3'd1:    r = 8'h61;
                    3'd2:    r = 8'h6C;
                    3'd3:    r = 8'h73;
                    3'd4:    r = 8'h65;
                    default: r = CH_NUL;
                endcase
            end
            2'd2: begin
                unique case (idx)
                    3'd0:    r = 8'h6E;
                    3'd1:    r = 8'h75;
                    3'd2:    r = 8'h6C;
                    3'd3:    r = 8'h6C;
                    default: r = CH_NUL;
                endcase
            end
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    // Drop every literal that cannot take letter c at position idx.
    function automatic logic [2:0] lit_filter(input logic [2:0] cand,
                                              input logic [2:0] idx,
                                              input logic [7:0] c);
        logic [2:0] r;
        r = cand;
        for (int k = 0; k < 3; k++) begin
            if ((idx >= lit_len(2'(k))) || (lit_char(2'(k), idx) != c)) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// ===== src/jtl_lex_core.sv =====
// Input register, lexer state machine and token formation for the JSON lexer.
module jtl_lex_core #(
    parameter int OFFSET_BITS = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     data_byte,
    input  logic           end_of_input,
    input  logic           space_ok,
    output jtl_pkg::push_t push
);
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_STR, MODE_STR_ESC, MODE_MINUS, MODE_ZERO, MODE_INT,
        MODE_DOT, MODE_FRAC, MODE_E, MODE_ESIGN, MODE_EXP, MODE_LIT
    } mode_t;

    localparam int OB = OFFSET_BITS;

    logic                   valid_reg, valid_next;
    logic [7:0]             byte_reg;
    logic                   eoi_reg;
    mode_t                  mode_reg, mode_next;
    logic [OB-1:0]          begin_reg, begin_next;
    logic [OB-1:0]          pos_reg, pos_next;
    logic [2:0]             cand_reg, cand_next;
    logic [2:0]             lidx_reg, lidx_next;
    logic                   err_reg, err_next;

    logic                   advance;
    logic                   end_item;
    logic [OB-1:0]          pos_inc;
    logic [OB-1:0]          len_cur;

    // pending-token close
    logic                   fl_valid, fl_err;
    jtl_pkg::tok_t          fl_tok;
    // outcome of lexing the byte from the idle mode
    logic                   id_emit, id_err;
    jtl_pkg::tok_t          id_tok;
    mode_t                  id_mode;
    logic [OB-1:0]          id_begin;
    logic [2:0]             id_cand, id_lidx;

    logic                   a_v, b_v;
    jtl_pkg::tok_t          a_tok, b_tok;
    logic                   do_idle, do_retry, do_flush;

    function automatic jtl_pkg::tok_t mk_tok(input logic [3:0] kind,
                                             input logic [2:0] err,
                                             input logic [OB-1:0] start,
                                             input logic [OB-1:0] len);
        jtl_pkg::tok_t t;
        t.kind  = kind;
        t.err   = err;
        t.start = jtl_pkg::TOK_W'(start);
        t.len   = jtl_pkg::TOK_W'(len);
        t.last  = 1'b0;
        return t;
    endfunction

    assign advance  = valid_reg && space_ok;
    assign in_ready = !valid_reg || advance;
    assign end_item = eoi_reg || (byte_reg == jtl_pkg::CH_NUL);
    assign pos_inc  = pos_reg + OB'(1);
    assign len_cur  = pos_reg - begin_reg;

    always_comb
    begin
        fl_valid = 1'b1;
        fl_err   = 1'b1;
        fl_tok   = mk_tok(jtl_pkg::KIND_ERROR, jtl_pkg::ERR_LITERAL, begin_reg, len_cur);
        unique case (mode_reg)
            MODE_STR, MODE_STR_ESC:
                fl_tok.err = jtl_pkg::ERR_UNTERM;
            MODE_MINUS:
                fl_tok.err = jtl_pkg::ERR_MINUS;
            MODE_DOT:
                fl_tok.err = jtl_pkg::ERR_FRACTION;
            MODE_E, MODE_ESIGN:
                fl_tok.err = jtl_pkg::ERR_EXPONENT;
            MODE_ZERO, MODE_INT, MODE_FRAC, MODE_EXP:
            begin
                fl_err = 1'b0;
                fl_tok = mk_tok(jtl_pkg::KIND_NUMBER, jtl_pkg::ERR_NONE, begin_reg, len_cur);
            end
            MODE_LIT:
            begin
                priority if (cand_reg[0] && (lidx_reg == jtl_pkg::lit_len(2'd0)))
                begin
                    fl_err = 1'b0;
                    fl_tok = mk_tok(jtl_pkg::KIND_TRUE, jtl_pkg::ERR_NONE, begin_reg, len_cur);
                end
                else if (cand_reg[1] && (lidx_reg == jtl_pkg::lit_len(2'd1)))
                begin
                    fl_err = 1'b0;
                    fl_tok = mk_tok(jtl_pkg::KIND_FALSE, jtl_pkg::ERR_NONE, begin_reg, len_cur);
                end
                else if (cand_reg[2] && (lidx_reg == jtl_pkg::lit_len(2'd2)))
                begin
                    fl_err = 1'b0;
                    fl_tok = mk_tok(jtl_pkg::KIND_NULL, jtl_pkg::ERR_NONE, begin_reg, len_cur);
                end
                else
                begin
                    fl_tok.err = jtl_pkg::ERR_LITERAL;
                end
            end
            default:
            begin
                fl_valid = 1'b0;
                fl_err   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        id_emit  = 1'b0;
        id_err   = 1'b0;
        id_mode  = MODE_IDLE;
        id_begin = pos_reg;
        id_cand  = cand_reg;
        id_lidx  = lidx_reg;
        id_tok   = mk_tok(jtl_pkg::KIND_ERROR, jtl_pkg::ERR_STRAY, pos_reg, OB'(1));
        priority if (jtl_pkg::is_space(byte_reg))
        begin
            id_begin = begin_reg;
        end
        else if ((byte_reg == jtl_pkg::CH_LBRACK) || (byte_reg == jtl_pkg::CH_RBRACK) ||
                 (byte_reg == jtl_pkg::CH_LBRACE) || (byte_reg == jtl_pkg::CH_RBRACE) ||
                 (byte_reg == jtl_pkg::CH_COLON)  || (byte_reg == jtl_pkg::CH_COMMA))
        begin
            id_emit  = 1'b1;
            id_begin = begin_reg;
            id_tok.err = jtl_pkg::ERR_NONE;
            priority case (byte_reg)
                jtl_pkg::CH_LBRACK: id_tok.kind = jtl_pkg::KIND_LBRACK;
                jtl_pkg::CH_RBRACK: id_tok.kind = jtl_pkg::KIND_RBRACK;
                jtl_pkg::CH_LBRACE: id_tok.kind = jtl_pkg::KIND_LBRACE;
                jtl_pkg::CH_RBRACE: id_tok.kind = jtl_pkg::KIND_RBRACE;
                jtl_pkg::CH_COLON:  id_tok.kind = jtl_pkg::KIND_COLON;
                default:            id_tok.kind = jtl_pkg::KIND_COMMA;
            endcase
        end
        else if (byte_reg == jtl_pkg::CH_QUOTE)
        begin
            id_mode  = MODE_STR;
            id_begin = pos_inc;
        end
        else if (byte_reg == jtl_pkg::CH_MINUS)
        begin
            id_mode = MODE_MINUS;
        end
        else if (byte_reg == jtl_pkg::CH_ZERO)
        begin
            id_mode = MODE_ZERO;
        end
        else if (jtl_pkg::is_digit(byte_reg))
        begin
            id_mode = MODE_INT;
        end
        else if (jtl_pkg::is_alpha(byte_reg))
        begin
            id_mode = MODE_LIT;
            id_cand = jtl_pkg::lit_filter(3'b111, 3'd0, byte_reg);
            id_lidx = 3'd1;
        end
        else
        begin
            id_emit = 1'b1;
            id_err  = 1'b1;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        mode_next  = mode_reg;
        begin_next = begin_reg;
        pos_next   = pos_reg;
        cand_next  = cand_reg;
        lidx_next  = lidx_reg;
        err_next   = err_reg;
        a_v        = 1'b0;
        b_v        = 1'b0;
        a_tok      = fl_tok;
        b_tok      = id_tok;
        do_idle    = 1'b0;
        do_retry   = 1'b0;
        do_flush   = 1'b0;

        if (in_ready)
        begin
            valid_next = in_valid;
        end

        if (end_item)
        begin
            a_v   = !err_reg && fl_valid;
            b_v   = 1'b1;
            b_tok = mk_tok(jtl_pkg::KIND_END, jtl_pkg::ERR_NONE, pos_reg, '0);
            mode_next  = MODE_IDLE;
            begin_next = '0;
            pos_next   = '0;
            cand_next  = 3'b111;
            lidx_next  = 3'd0;
            err_next   = 1'b0;
        end
        else
        begin
            pos_next = pos_inc;
            if (!err_reg)
            begin
                unique case (mode_reg)
                    MODE_STR:
                    begin
                        if (byte_reg == jtl_pkg::CH_BACKSLASH)
                        begin
                            mode_next = MODE_STR_ESC;
                        end
                        else if (byte_reg == jtl_pkg::CH_QUOTE)
                        begin
                            a_v   = 1'b1;
                            a_tok = mk_tok(jtl_pkg::KIND_STRING, jtl_pkg::ERR_NONE,
                                           begin_reg, len_cur);
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_STR_ESC:
                        mode_next = MODE_STR;
                    MODE_MINUS:
                    begin
                        if (byte_reg == jtl_pkg::CH_ZERO)
                            mode_next = MODE_ZERO;
                        else if (jtl_pkg::is_digit(byte_reg))
                            mode_next = MODE_INT;
                        else
                            do_flush = 1'b1;
                    end
                    MODE_ZERO, MODE_INT, MODE_FRAC:
                    begin
                        if ((mode_reg != MODE_ZERO) && jtl_pkg::is_digit(byte_reg))
                            mode_next = mode_reg;
                        else if ((byte_reg == jtl_pkg::CH_DOT) && (mode_reg != MODE_FRAC))
                            mode_next = MODE_DOT;
                        else if (jtl_pkg::is_exp_mark(byte_reg))
                            mode_next = MODE_E;
                        else
                            do_retry = 1'b1;
                    end
                    MODE_DOT:
                    begin
                        if (jtl_pkg::is_digit(byte_reg))
                            mode_next = MODE_FRAC;
                        else
                            do_flush = 1'b1;
                    end
                    MODE_E:
                    begin
                        if ((byte_reg == jtl_pkg::CH_PLUS) || (byte_reg == jtl_pkg::CH_MINUS))
                            mode_next = MODE_ESIGN;
                        else if (jtl_pkg::is_digit(byte_reg))
                            mode_next = MODE_EXP;
                        else
                            do_flush = 1'b1;
                    end
                    MODE_ESIGN:
                    begin
                        if (jtl_pkg::is_digit(byte_reg))
                            mode_next = MODE_EXP;
                        else
                            do_flush = 1'b1;
                    end
                    MODE_EXP:
                    begin
                        if (!jtl_pkg::is_digit(byte_reg))
                            do_retry = 1'b1;
                    end
                    MODE_LIT:
                    begin
                        if (jtl_pkg::is_alpha(byte_reg))
                        begin
                            cand_next = jtl_pkg::lit_filter(cand_reg, lidx_reg, byte_reg);
                            if (lidx_reg != 3'd7)
                                lidx_next = lidx_reg + 3'd1;
                        end
                        else
                        begin
                            do_retry = 1'b1;
                        end
                    end
                    default:
                        do_idle = 1'b1;
                endcase
            end

            // incomplete token: error, then drop bytes until end item
            if (do_flush)
            begin
                a_v       = 1'b1;
                mode_next = MODE_IDLE;
                err_next  = 1'b1;
            end

            // close the pending token, then relex this byte if that was clean
            if (do_retry)
            begin
                a_v       = 1'b1;
                mode_next = MODE_IDLE;
                if (fl_err)
                    err_next = 1'b1;
            end

            if (do_idle || (do_retry && !fl_err))
            begin
                mode_next  = id_mode;
                begin_next = id_begin;
                cand_next  = id_cand;
                lidx_next  = id_lidx;
                err_next   = id_err;
                if (do_idle)
                begin
                    a_v   = id_emit;
                    a_tok = id_tok;
                end
                else
                begin
                    b_v = id_emit;
                end
            end
        end
    end

    always_comb
    begin
        push = '0;
        if (a_v)
        begin
            push.tok0 = a_tok;
            push.tok1 = b_tok;
            push.count = b_v ? 2'd2 : 2'd1;
            if (b_v)
                push.tok1.last = 1'b1;
            else
                push.tok0.last = 1'b1;
        end
        else if (b_v)
        begin
            push.tok0      = b_tok;
            push.tok0.last = 1'b1;
            push.count     = 2'd1;
        end
        if (!advance)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mode_reg  <= MODE_IDLE;
            begin_reg <= '0;
            pos_reg   <= '0;
            cand_reg  <= 3'b111;
            lidx_reg  <= 3'd0;
            err_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (advance)
            begin
                mode_reg  <= mode_next;
                begin_reg <= begin_next;
                pos_reg   <= pos_next;
                cand_reg  <= cand_next;
                lidx_reg  <= lidx_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            eoi_reg  <= end_of_input;
        end
    end

    `JTL_ASSERT_NEXT(a_end_resets, advance && end_item,
                     pos_reg == '0 && mode_reg == MODE_IDLE && !err_reg,
                     "end item did not return lexer to reset state")
    `JTL_ASSERT_NOW(a_end_emits, advance && end_item,
                    push.count != 2'd0, "end item produced no token")
    `JTL_ASSERT_NOW(a_err_silent, advance && err_reg && !end_item,
                    push.count == 2'd0, "token emitted while dropping after error")
endmodule

// ===== src/jtl_token_fifo.sv =====
// Four-entry token queue that takes up to two tokens a cycle and releases one.
module jtl_token_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  jtl_pkg::push_t push,
    output logic           space_ok,
    output logic           out_valid,
    input  logic           out_ready,
    output jtl_pkg::tok_t  out_tok
);
    `include "assert_macros.svh"

    jtl_pkg::tok_t                  mem_reg [jtl_pkg::FIFO_DEPTH];
    logic [jtl_pkg::FIFO_PTR_W-1:0] wptr_reg, wptr_next;
    logic [jtl_pkg::FIFO_PTR_W-1:0] rptr_reg, rptr_next;
    logic [jtl_pkg::FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic [jtl_pkg::FIFO_PTR_W-1:0] wptr_inc;
    logic                           pop;

    assign space_ok  = cnt_reg <= jtl_pkg::FIFO_CNT_W'(jtl_pkg::FIFO_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_tok   = mem_reg[rptr_reg];
    assign pop       = out_valid && out_ready;
    assign wptr_inc  = wptr_reg + jtl_pkg::FIFO_PTR_W'(1);

    always_comb
    begin
        wptr_next = wptr_reg + jtl_pkg::FIFO_PTR_W'(push.count);
        rptr_next = rptr_reg + jtl_pkg::FIFO_PTR_W'(pop);
        cnt_next  = cnt_reg + jtl_pkg::FIFO_CNT_W'(push.count)
                  - jtl_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wptr_reg] <= push.tok0;
        if (push.count == 2'd2)
            mem_reg[wptr_inc] <= push.tok1;
    end

    `JTL_ASSERT_NOW(a_no_overflow, push.count != 2'd0,
                    (32'(cnt_reg) + 32'(push.count)) <= jtl_pkg::FIFO_DEPTH,
                    "token queue overflow")
    `JTL_ASSERT_NOW(a_count_range, 1'b1, cnt_reg <= jtl_pkg::FIFO_CNT_W'(jtl_pkg::FIFO_DEPTH),
                    "token queue count out of range")
    `JTL_ASSERT_NEXT(a_ptr_track, pop && push.count == 2'd0,
                     cnt_reg == $past(cnt_reg) - jtl_pkg::FIFO_CNT_W'(1),
                     "token queue count lost track of a pop")
endmodule

// ===== src/json_token_lexer.sv =====
// Top level of the streaming JSON token lexer.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  input    | in_valid / in_ready   | data_byte, end_of_input
//  output   | out_valid / out_ready | token_kind, error_code, token_start,
//           |                       | token_length, last_of_run
//
// One byte request is taken per cycle when the token queue has room for two
// more tokens; the lexer state machine handles each byte from the input register.
// A byte gives at most two tokens; the queue drains one token per cycle, so
// the input stalls only when tokens pile up or out_ready is held low.
// A request passes the input register, then the token queue, before its first token is out.
// Reset (rst_n low, asynchronous) empties input register and queue and puts
// the lexer at offset zero with no token pending.
module json_token_lexer #(
    parameter int OFFSET_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [2:0]  error_code,
    output logic [23:0] token_start,
    output logic [23:0] token_length,
    output logic        last_of_run
);
    jtl_pkg::push_t push;
    jtl_pkg::tok_t  out_tok;
    logic           space_ok;

    // Lexer: input register, mode machine, offsets, literal matcher.
    jtl_lex_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .space_ok     (space_ok),
        .push         (push)
    );

    // Token queue doubles as the output register stage.
    jtl_token_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_tok   (out_tok)
    );

    assign token_kind   = out_tok.kind;
    assign error_code   = out_tok.err;
    assign token_start  = out_tok.start;
    assign token_length = out_tok.len;
    assign last_of_run  = out_tok.last;
endmodule

// ===== tb/json_token_lexer_checker.sv =====
// Token predictor and scoreboard for the JSON token lexer.
module json_token_lexer_checker
    import jtl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  token_kind,
    input  logic [2:0]  error_code,
    input  logic [23:0] token_start,
    input  logic [23:0] token_length,
    input  logic        last_of_run,
    output int          mismatch_count,
    output int          tokens_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        LX_IDLE, LX_STR, LX_STR_ESC, LX_MINUS, LX_ZERO, LX_INT,
        LX_DOT, LX_FRAC, LX_E, LX_ESIGN, LX_EXP, LX_LIT
    } lex_mode_t;

    localparam logic [7:0] CH_LOWER_E = "e";
    localparam logic [7:0] CH_UPPER_E = "E";

    string      lit_words [3] = '{"true", "false", "null"};
    logic [3:0] lit_kinds [3] = '{KIND_TRUE, KIND_FALSE, KIND_NULL};

    // lexer state as the block should hold it
    lex_mode_t   mode;
    logic [23:0] tok_begin;
    logic [23:0] pos;
    logic [2:0]  lit_cand;
    logic [2:0]  lit_idx;
    logic        err_flag;

    tok_t step_toks[$];
    tok_t tokens_due[$];

    function automatic logic digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function void clear_lexer();
        mode     = LX_IDLE;
        tok_begin = '0;
        pos      = '0;
        lit_cand = 3'b111;
        lit_idx  = '0;
        err_flag = 1'b0;
    endfunction

    function void push_tok(input logic [3:0] kind, input logic [2:0] code,
                           input logic [23:0] start, input logic [23:0] len);
        tok_t t;
        t.kind  = kind;
        t.err   = code;
        t.start = start;
        t.len   = len;
        t.last  = 1'b0;
        step_toks.push_back(t);
    endfunction

    function void raise_error(input logic [2:0] code);
        push_tok(KIND_ERROR, code, tok_begin, pos - tok_begin);
        err_flag = 1'b1;
        mode     = LX_IDLE;
    endfunction

    // end the token in progress at the current offset
    function void close_token();
        logic done;
        done = 1'b0;
        case (mode)
            LX_STR, LX_STR_ESC: raise_error(ERR_UNTERM);
            LX_MINUS:           raise_error(ERR_MINUS);
            LX_DOT:             raise_error(ERR_FRACTION);
            LX_E, LX_ESIGN:     raise_error(ERR_EXPONENT);
            LX_ZERO, LX_INT, LX_FRAC, LX_EXP:
                push_tok(KIND_NUMBER, ERR_NONE, tok_begin, pos - tok_begin);
            LX_LIT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (!done && lit_cand[k] && lit_idx == 3'(lit_words[k].len()))
                    begin
                        push_tok(lit_kinds[k], ERR_NONE, tok_begin, pos - tok_begin);
                        done = 1'b1;
                    end
                end
                if (!done)
                    raise_error(ERR_LITERAL);
            end
            default: ;
        endcase
        mode = LX_IDLE;
    endfunction

    function void feed_literal(input logic [7:0] c);
        for (int k = 0; k < 3; k++)
        begin
            if (lit_idx >= 3'(lit_words[k].len()) || lit_words[k][lit_idx] != c)
                lit_cand[k] = 1'b0;
        end
        if (lit_idx < 3'd7)
            lit_idx = lit_idx + 3'd1;
    endfunction

    function void lex_fresh(input logic [7:0] c);
        logic [3:0] glyph;
        glyph = KIND_END;
        case (c)
            " ", "\t", "\n", "\v", "\f", "\r": return;
            CH_LBRACK: glyph = KIND_LBRACK;
            CH_RBRACK: glyph = KIND_RBRACK;
            CH_LBRACE: glyph = KIND_LBRACE;
            CH_RBRACE: glyph = KIND_RBRACE;
            CH_COLON:  glyph = KIND_COLON;
            CH_COMMA:  glyph = KIND_COMMA;
            CH_QUOTE:
            begin
                mode      = LX_STR;
                tok_begin = pos + 24'd1;
                return;
            end
            default: ;
        endcase
        if (glyph != KIND_END)
        begin
            push_tok(glyph, ERR_NONE, pos, 24'd1);
            return;
        end
        tok_begin = pos;
        if (c == CH_MINUS)
            mode = LX_MINUS;
        else if (c == CH_ZERO)
            mode = LX_ZERO;
        else if (digit(c))
            mode = LX_INT;
        else if (letter(c))
        begin
            mode     = LX_LIT;
            lit_cand = 3'b111;
            lit_idx  = '0;
            feed_literal(c);
        end
        else
        begin
            push_tok(KIND_ERROR, ERR_STRAY, pos, 24'd1);
            err_flag = 1'b1;
        end
    endfunction

    // a byte that cannot extend the token closes it and is lexed again
    function void close_and_retry(input logic [7:0] c);
        close_token();
        if (!err_flag)
            lex_fresh(c);
    endfunction

    function void lex_char(input logic [7:0] c);
        logic is_e;
        is_e = (c == CH_LOWER_E) || (c == CH_UPPER_E);
        case (mode)
            LX_STR:
                if (c == CH_BACKSLASH)
                    mode = LX_STR_ESC;
                else if (c == CH_QUOTE)
                begin
                    push_tok(KIND_STRING, ERR_NONE, tok_begin, pos - tok_begin);
                    mode = LX_IDLE;
                end
            LX_STR_ESC: mode = LX_STR;
            LX_MINUS:
                if (c == CH_ZERO)
                    mode = LX_ZERO;
                else if (digit(c))
                    mode = LX_INT;
                else
                    close_token();
            LX_ZERO, LX_INT, LX_FRAC:
                if ((mode == LX_INT || mode == LX_FRAC) && digit(c))
                    ;
                else if (c == CH_DOT && mode != LX_FRAC)
                    mode = LX_DOT;
                else if (is_e)
                    mode = LX_E;
                else
                    close_and_retry(c);
            LX_DOT:
                if (digit(c))
                    mode = LX_FRAC;
                else
                    close_token();
            LX_E:
                if (c == CH_PLUS || c == CH_MINUS)
                    mode = LX_ESIGN;
                else if (digit(c))
                    mode = LX_EXP;
                else
                    close_token();
            LX_ESIGN:
                if (digit(c))
                    mode = LX_EXP;
                else
                    close_token();
            LX_EXP:
                if (!digit(c))
                    close_and_retry(c);
            LX_LIT:
                if (letter(c))
                    feed_literal(c);
                else
                    close_and_retry(c);
            default: lex_fresh(c);
        endcase
    endfunction

    function void predict_tokens(input logic [7:0] b, input logic eoi);
        step_toks.delete();
        if (eoi || b == CH_NUL)
        begin
            if (!err_flag)
                close_token();
            push_tok(KIND_END, ERR_NONE, pos, 24'd0);
            clear_lexer();
        end
        else
        begin
            if (!err_flag)
                lex_char(b);
            pos = pos + 24'd1;
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i])
            tokens_due.push_back(step_toks[i]);
    endfunction

    function void compare_field(input string field, input logic [23:0] want,
                                input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tok_t t;
        if (!rst_n)
        begin
            clear_lexer();
            tokens_due.delete();
            mismatch_count = 0;
        end
        else
        begin
            // input first, so a same-edge token is never seen as unexpected
            if (in_valid && in_ready)
                predict_tokens(data_byte, end_of_input);
            if (out_valid && out_ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    $error("token with none pending: kind %0d start %0d",
                           token_kind, token_start);
                    mismatch_count++;
                end
                else
                begin
                    t = tokens_due.pop_front();
                    compare_field("token_kind", 24'(t.kind), 24'(token_kind));
                    compare_field("error_code", 24'(t.err), 24'(error_code));
                    compare_field("token_start", t.start, token_start);
                    compare_field("token_length", t.len, token_length);
                    compare_field("last_of_run", 24'(t.last), 24'(last_of_run));
                end
            end
        end
        tokens_pending = tokens_due.size();
    end

endmodule

// ===== tb/json_token_lexer_test.sv =====
// Testbench top for the JSON token lexer: clock, reset, byte stimulus, verdict.
module json_token_lexer_test;
    import jtl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run length: about 600 byte requests in each of three idle settings.
    localparam int PHASE_REQUESTS = 600;
    // Receiver hold-off used to back the token queue up into the input.
    localparam int HOLD_CYCLES    = 300;
    // Far above the slowest legal run (two tokens per byte, long receiver stalls).
    localparam int CYCLE_LIMIT    = 500000;
    // Settle time after the last token.
    localparam int SETTLE_CYCLES  = 20;

    typedef enum {FLAW_NONE, FLAW_MINUS, FLAW_FRACTION, FLAW_EXPONENT} num_flaw_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte    = '0;
    logic        end_of_input = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [3:0]  token_kind;
    logic [2:0]  error_code;
    logic [23:0] token_start;
    logic [23:0] token_length;
    logic        last_of_run;

    int mismatch_count;
    int tokens_pending;

    // Idle odds in percent for each side, and the hold-off request counters.
    int send_idle_pct = 31;
    int recv_idle_pct = 87;
    int holds_asked   = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int requests_sent = 0;
    int cycle_count   = 0;

    // Bytes of the stream being built, sent in order before its terminator.
    logic [7:0] text_q[$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    json_token_lexer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .error_code   (error_code),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    json_token_lexer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_input   (end_of_input),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .token_kind     (token_kind),
        .error_code     (error_code),
        .token_start    (token_start),
        .token_length   (token_length),
        .last_of_run    (last_of_run),
        .mismatch_count (mismatch_count),
        .tokens_pending (tokens_pending)
    );

    // Receiver: random ready, unless a long hold-off has been asked for.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            out_ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // One byte request. Optional idle cycles go first; valid then holds with a
    // steady payload until the request is taken.
    task automatic send_request(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_input <= eoi;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Send the built text, then close the stream either with an end request
    // (payload byte random, it must be ignored) or with a zero byte.
    task automatic send_stream(input logic by_eoi);
        logic [7:0] b;
        while (text_q.size() > 0)
        begin
            b = text_q.pop_front();
            send_request(b, 1'b0);
        end
        if (by_eoi)
            send_request(8'($urandom_range(255)), 1'b1);
        else
            send_request(CH_NUL, 1'b0);
    endtask

    // Stop offering bytes until every predicted token has come out.
    task automatic drain_tokens();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] any_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    // Number under the JSON grammar; now and then one required digit is left
    // out so the minus, fraction or exponent error comes up.
    task automatic put_number();
        num_flaw_t flaw;
        flaw = FLAW_NONE;
        if ($urandom_range(9) == 0)
            flaw = num_flaw_t'($urandom_range(1, 3));
        if (flaw == FLAW_MINUS || $urandom_range(2) == 0)
            text_q.push_back(CH_MINUS);
        if (flaw == FLAW_MINUS)
            return;
        if ($urandom_range(3) == 0)
            text_q.push_back(CH_ZERO);
        else
        begin
            text_q.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
            repeat ($urandom_range(4)) text_q.push_back(any_digit());
        end
        if (flaw == FLAW_FRACTION || $urandom_range(3) == 0)
        begin
            text_q.push_back(CH_DOT);
            if (flaw != FLAW_FRACTION)
                repeat ($urandom_range(1, 3)) text_q.push_back(any_digit());
        end
        if (flaw == FLAW_EXPONENT || $urandom_range(3) == 0)
        begin
            text_q.push_back($urandom_range(1) ? "e" : "E");
            if ($urandom_range(1))
                text_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
            if (flaw != FLAW_EXPONENT)
                repeat ($urandom_range(1, 2)) text_q.push_back(any_digit());
        end
    endtask

    // String body: mostly printable text, some escapes of any nonzero byte, some high
    // bytes; usually closed, sometimes left open to hit the unterminated case.
    task automatic put_string();
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(6))
        begin
            case ($urandom_range(9))
                0:
                begin
                    text_q.push_back(CH_BACKSLASH);
                    text_q.push_back(8'($urandom_range(1, 255)));
                end
                1:       text_q.push_back(8'($urandom_range(128, 255)));
                default: text_q.push_back(8'($urandom_range(32, 126)));
            endcase
        end
        if ($urandom_range(9) != 0)
            text_q.push_back(CH_QUOTE);
    endtask

    // true/false/null, or a near miss: cut short, one letter too many, or
    // a random run of letters.
    task automatic put_literal();
        string words[3];
        string w;
        words = '{"true", "false", "null"};
        w = words[$urandom_range(2)];
        case ($urandom_range(9))
            0: put_text(w.substr(0, w.len() - 2));
            1:
            begin
                put_text(w);
                text_q.push_back(8'($urandom_range("a", "z")));
            end
            2:
                repeat ($urandom_range(1, 6))
                    text_q.push_back($urandom_range(1) ? 8'($urandom_range("a", "z"))
                                                       : 8'($urandom_range("A", "Z")));
            default: put_text(w);
        endcase
    endtask

    // Mostly well-formed token runs with random content; separators are often
    // left out so one byte closes a token and opens the next.
    task automatic build_stream();
        string glyphs;
        string blanks;
        glyphs = "[]{}:,";
        blanks = " \t\n\r\v\f";
        repeat ($urandom_range(1, 10))
        begin
            case ($urandom_range(19))
                0, 1:          text_q.push_back(blanks[$urandom_range(5)]);
                2, 3, 4, 5:    text_q.push_back(glyphs[$urandom_range(5)]);
                6, 7, 8, 9:    put_string();
                10, 11, 12, 13, 14: put_number();
                15, 16, 17:    put_literal();
                default:       text_q.push_back(8'($urandom_range(255)));
            endcase
            if ($urandom_range(1))
                text_q.push_back(" ");
        end
    endtask

    initial
    begin
        int phase_base;
        int keep_pct;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every glyph kind but '[' and '}' first, an escaped quote in a
        // string, leading zero splitting "01e5", null closed by a glyph, and the
        // stream ended by a zero byte.
        put_text("{\"\\\"\":01e5,null]");
        send_stream(1'b0);
        // No digit after minus; bytes after the error (0xFF too) are dropped.
        put_text("-x");
        text_q.push_back(8'hFF);
        send_stream(1'b1);
        // Stray byte right after a comma.
        put_text(",");
        text_q.push_back(8'hFF);
        send_stream(1'b1);
        // String still open at the end request.
        put_text("\"a");
        send_stream(1'b1);
        drain_tokens();

        // Three idle settings: receiver-heavy, sender-heavy, then none.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct <= 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct <= 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            phase_base = requests_sent;

            if (phase == 2)
            begin
                // Receiver holds off while '[' requests keep coming back to
                // back: the token queue fills and in_ready must drop.
                holds_asked <= holds_asked + 1;
                keep_pct = send_idle_pct;
                send_idle_pct = 0;
                repeat (60) text_q.push_back(CH_LBRACK);
                send_stream(1'b1);
                send_idle_pct = keep_pct;
            end

            while (requests_sent - phase_base < PHASE_REQUESTS)
            begin
                build_stream();
                send_stream($urandom_range(9) < 7);
            end
            // Sender pauses until all tokens of this phase are out.
            drain_tokens();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && tokens_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
